### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the sensor frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int PAYLOAD_LEN = 9;
   localparam int COUNT_W     = 4;
   localparam int SLOT_W      = 3;
   localparam int TABLE_DEPTH = 8;
   localparam int VALUE_W     = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [7:0]         SYNC_BYTE   = 8'hFF;
   localparam logic [7:0]         FAULT_MARK  = 8'hFE;
   localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'd4000;

   // register indexes (word address)
   localparam logic REG_DISTANCE_LIMIT = 1'b0;

   // item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // event codes
   localparam logic [1:0] EV_GOOD   = 2'd0;
   localparam logic [1:0] EV_REJECT = 2'd1;
   localparam logic [1:0] EV_READ   = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
      logic [2:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_res;
      logic               ir_first;
      logic               ir_second;
      logic [SLOT_W-1:0]  slot_first;
      logic [SLOT_W-1:0]  slot_second;
      logic [VALUE_W-1:0] table_value;
      logic [VALUE_W-1:0] laser0_distance;
      logic               laser0_on;
      logic               laser0_fault;
      logic [VALUE_W-1:0] laser1_distance;
      logic               laser1_on;
      logic               laser1_fault;
   } rsp_type;

   typedef logic [PAYLOAD_LEN-1:0][7:0] payload_type;

   typedef struct packed {
      logic end_pending;  // nine payload bytes held, next byte is the checksum
      logic sum_match;    // running sum equals the byte now offered
   } frame_status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] distance;
      logic               on;
      logic               fault;
   } laser_type;

   typedef struct packed {
      logic              ir_first;
      logic              ir_second;
      logic [SLOT_W-1:0] slot_first;
      logic [SLOT_W-1:0] slot_second;
      laser_type         laser0;
      laser_type         laser1;
   } view_type;

endpackage

### rtl/sfr_framer.sv
// ----------------------------------------------------------------------------
// sfr_framer
// Sync hunt, payload capture and running checksum.
// ----------------------------------------------------------------------------
module sfr_framer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output sfr_pkg::frame_status_type status,
   output sfr_pkg::payload_type     payload
);
   import sfr_pkg::*;

   typedef enum logic [1:0] {
      PH_SYNC1 = 2'd0,
      PH_SYNC2 = 2'd1,
      PH_BODY  = 2'd2
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   payload_type        payload_ff;
   logic               write_en;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      write_en = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               if (rx_byte == SYNC_BYTE) begin
                  phase_in = PH_BODY;
                  count_in = '0;
                  sum_in   = '0;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_BODY: begin
               if (count_ff < COUNT_W'(PAYLOAD_LEN)) begin
                  write_en = 1'b1;
                  sum_in   = sum_ff + rx_byte;
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  // checksum byte closes the frame
                  phase_in = PH_SYNC1;
                  count_in = '0;
                  sum_in   = '0;
               end
            end
            default: begin
               // first sync, also the unused phase code
               phase_in = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         for (int i = 0; i < PAYLOAD_LEN; i++) begin
            if (write_en && (count_ff == COUNT_W'(i))) begin
               payload_ff[i] <= rx_byte;
            end
         end
      end
   end

   assign status.end_pending = (phase_ff == PH_BODY) && (count_ff == COUNT_W'(PAYLOAD_LEN));
   assign status.sum_match   = (sum_ff == rx_byte);
   assign payload            = payload_ff;

endmodule

### rtl/sfr_state.sv
// ----------------------------------------------------------------------------
// sfr_state
// Decoded frame values: IR flags, range table and laser channels.
// ----------------------------------------------------------------------------
module sfr_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                apply,
   input  sfr_pkg::payload_type                payload,
   input  logic [sfr_pkg::VALUE_W-1:0]         distance_limit,
   input  logic [sfr_pkg::SLOT_W-1:0]          read_index,
   output sfr_pkg::view_type                   view,
   output logic [sfr_pkg::VALUE_W-1:0]         table_value
);
   import sfr_pkg::*;

   logic [TABLE_DEPTH-1:0][VALUE_W-1:0] range_ff, range_in;
   logic [1:0]                          ir_ff, ir_in;
   logic [SLOT_W-1:0]                   slot0_ff, slot0_in, slot1_ff, slot1_in;
   laser_type                           laser0_ff, laser0_in, laser1_ff, laser1_in;

   function automatic laser_type laser_next(laser_type cur, logic [7:0] lo, logic [7:0] hi,
                                            logic [VALUE_W-1:0] limit);
      laser_type          nxt;
      logic [VALUE_W-1:0] v;
      nxt = cur;
      v   = {hi, lo};
      if (v == '0) begin
         nxt.on       = 1'b0;
         nxt.distance = '0;
      end else if (hi != FAULT_MARK) begin
         nxt.on    = 1'b1;
         nxt.fault = 1'b0;
         if (v < limit) begin
            nxt.distance = v;
         end
      end else begin
         nxt.fault = 1'b1;
      end
      return nxt;
   endfunction

   always_comb begin
      range_in  = range_ff;
      ir_in     = ir_ff;
      slot0_in  = slot0_ff;
      slot1_in  = slot1_ff;
      laser0_in = laser0_ff;
      laser1_in = laser1_ff;
      if (apply) begin
         ir_in     = payload[8][1:0];
         slot0_in  = payload[8][4:2];
         slot1_in  = payload[8][7:5];
         // second slot written last so it wins on a clash
         range_in[payload[8][4:2]] = {payload[1], payload[0]};
         range_in[payload[8][7:5]] = {payload[3], payload[2]};
         laser0_in = laser_next(laser0_ff, payload[4], payload[5], distance_limit);
         laser1_in = laser_next(laser1_ff, payload[6], payload[7], distance_limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= '0;
         ir_ff     <= '0;
         slot0_ff  <= '0;
         slot1_ff  <= '0;
         laser0_ff <= '0;
         laser1_ff <= '0;
      end else begin
         range_ff  <= range_in;
         ir_ff     <= ir_in;
         slot0_ff  <= slot0_in;
         slot1_ff  <= slot1_in;
         laser0_ff <= laser0_in;
         laser1_ff <= laser1_in;
      end
   end

   // values after this item's update
   assign view.ir_first    = ir_in[0];
   assign view.ir_second   = ir_in[1];
   assign view.slot_first  = slot0_in;
   assign view.slot_second = slot1_in;
   assign view.laser0      = laser0_in;
   assign view.laser1      = laser1_in;
   assign table_value      = range_ff[read_index];

endmodule

### rtl/sensor_frame_receiver.sv
// ----------------------------------------------------------------------------
// sensor_frame_receiver
// Byte-wise sensor link frame receiver with range table and laser status.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one transfer per item, either a received link byte (kind 0) or a
//           range table read (kind 1, read_index picks the slot).
//   rsp_* : one transfer per frame end (good frame or checksum reject) and
//           per table read; bytes inside a frame produce no transfer.
//   APB   : distance_limit at byte address 0, reset 4000; pready tied high.
//           Write it only while the block is idle.
// Path: a taken item sits in the input register; its result is registered
//   in the result register, which drives rsp_valid. Throughput: one item
//   per cycle while no held result blocks it (see Stall). The input register
//   feeds a single pass of framer and decode logic into the result register.
// Stall: while rsp_ready is low a held result blocks only items that would
//   make another result; plain payload bytes keep flowing. req_ready follows
//   rsp_ready combinationally through the input register's drain condition.
// Reset: synchronous, active high; hunting restarts at the first sync byte,
//   table and laser values clear to zero, limit returns to 4000.
// ----------------------------------------------------------------------------
module sensor_frame_receiver (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sfr_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sfr_pkg::rsp_type                  rsp_data,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import sfr_pkg::*;

   // input register
   req_type  req_ff;
   logic     req_valid_ff, req_valid_in;

   // result register
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [VALUE_W-1:0] limit_ff, limit_in;
   logic               csr_write;
   logic               csr_hit;

   // datapath control
   frame_status_type   status;
   payload_type        payload;
   view_type           view;
   logic [VALUE_W-1:0] table_value;
   logic               out_free;
   logic               is_read;
   logic               produces;
   logic               consume;
   logic               step;
   logic               apply;

   // ---------------------------------------------------------------------
   // Flow control: the held item drains when it makes no result or the
   // result register is free (empty or being emptied this cycle).
   // ---------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_read   = (req_ff.kind == KIND_READ);
   assign produces  = is_read || status.end_pending;
   assign consume   = req_valid_ff && (out_free || !produces);
   assign req_ready = !req_valid_ff || consume;

   assign step  = consume && !is_read;
   assign apply = step && status.end_pending && status.sum_match;

   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------------
   // Framer and decoded state
   // ---------------------------------------------------------------------
   sfr_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_ff.rx_byte),
      .status  (status),
      .payload (payload)
   );

   sfr_state u_state (
      .clock          (clock),
      .reset          (reset),
      .apply          (apply),
      .payload        (payload),
      .distance_limit (limit_ff),
      .read_index     (req_ff.read_index),
      .view           (view),
      .table_value    (table_value)
   );

   // ---------------------------------------------------------------------
   // Result build: frame events carry the values after the update, a
   // reject or a read carries them unchanged.
   // ---------------------------------------------------------------------
   always_comb begin
      if (is_read) begin
         rsp_in.event_res   = EV_READ;
         rsp_in.table_value = table_value;
      end else begin
         rsp_in.event_res   = status.sum_match ? EV_GOOD : EV_REJECT;
         rsp_in.table_value = '0;
      end
      rsp_in.ir_first        = view.ir_first;
      rsp_in.ir_second       = view.ir_second;
      rsp_in.slot_first      = view.slot_first;
      rsp_in.slot_second     = view.slot_second;
      rsp_in.laser0_distance = view.laser0.distance;
      rsp_in.laser0_on       = view.laser0.on;
      rsp_in.laser0_fault    = view.laser0.fault;
      rsp_in.laser1_distance = view.laser1.distance;
      rsp_in.laser1_on       = view.laser1.on;
      rsp_in.laser1_fault    = view.laser1.fault;
   end

   assign rsp_valid_in = (consume && produces) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && produces) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == REG_DISTANCE_LIMIT);
   assign csr_write = psel && penable && pwrite && pready;
   assign limit_in  = (csr_write && csr_hit) ? pwdata[VALUE_W-1:0] : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata = csr_hit ? CSR_DATA_W'(limit_ff) : '0;

endmodule

### tb/sv/tb_sensor_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_receiver
// Self-checking bench for the sensor frame receiver. Link bytes and range table
// reads are sent over the request channel. A local tracker of the framer, range
// table and laser state works out each status transfer, and every transfer on
// the result channel is compared field by field with the oldest expected one.
// Random bursts of idle cycles fall on both channels, and the distance limit is
// set to several values between traffic phases.
// ----------------------------------------------------------------------------
module tb_sensor_frame_receiver;
   import sfr_pkg::*;

   // no transfer on either channel for this many cycles ends the run
   localparam int QUIET_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = {REG_DISTANCE_LIMIT, 2'b00};

   typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, IN_BODY} hunt_state_type;

   // DUT signals, the driven inputs known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // tracked receiver state
   logic [VALUE_W-1:0]    limit_q;
   hunt_state_type        hunt;
   int                    body_count;
   logic [7:0]            body_sum;
   payload_type           body_bytes;
   logic [VALUE_W-1:0]    range_mem [TABLE_DEPTH];
   logic [1:0]            ir_bits;
   logic [SLOT_W-1:0]     slot_a;
   logic [SLOT_W-1:0]     slot_b;
   logic [VALUE_W-1:0]    laser_dist [2];
   logic                  laser_on [2];
   logic                  laser_fault [2];

   // status transfers still owed by the receiver, oldest first
   rsp_type               status_reports [$];
   rsp_type               want;

   // bookkeeping
   bit                    gaps_on = 1'b0;
   int                    stall_left = 0;
   int                    quiet_cycles = 0;
   int                    error_count = 0;
   int                    accepted_items = 0;
   int                    n_bytes = 0;
   int                    n_reads = 0;
   int                    n_good = 0;
   int                    n_reject = 0;
   int                    n_limits = 0;

   sensor_frame_receiver uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Receiver tracker
   // ------------------------------------------------------------------------
   task automatic clear_tracker();
      limit_q    = LIMIT_RESET;
      hunt       = HUNT_FIRST;
      body_count = 0;
      body_sum   = '0;
      body_bytes = '0;
      ir_bits    = '0;
      slot_a     = '0;
      slot_b     = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) range_mem[i] = '0;
      for (int c = 0; c < 2; c++) begin
         laser_dist[c]  = '0;
         laser_on[c]    = 1'b0;
         laser_fault[c] = 1'b0;
      end
   endtask

   // snapshot of the stored values as the receiver reports them
   function automatic rsp_type status_word(input logic [1:0] ev, input logic [VALUE_W-1:0] tv);
      rsp_type r;
      r.event_res       = ev;
      r.ir_first        = ir_bits[0];
      r.ir_second       = ir_bits[1];
      r.slot_first      = slot_a;
      r.slot_second     = slot_b;
      r.table_value     = tv;
      r.laser0_distance = laser_dist[0];
      r.laser0_on       = laser_on[0];
      r.laser0_fault    = laser_fault[0];
      r.laser1_distance = laser_dist[1];
      r.laser1_on       = laser_on[1];
      r.laser1_fault    = laser_fault[1];
      return r;
   endfunction

   // zero clears the channel, a 0xFE high byte only flags a fault,
   // anything else turns it on and keeps the reading when under the limit
   task automatic update_laser(input int ch, input logic [VALUE_W-1:0] v);
      if (v == '0) begin
         laser_on[ch]   = 1'b0;
         laser_dist[ch] = '0;
      end else if (v[15:8] != FAULT_MARK) begin
         laser_on[ch]    = 1'b1;
         laser_fault[ch] = 1'b0;
         if (v < limit_q) laser_dist[ch] = v;
      end else begin
         laser_fault[ch] = 1'b1;
      end
   endtask

   task automatic apply_payload();
      logic [7:0] f;
      f       = body_bytes[8];
      ir_bits = f[1:0];
      slot_a  = f[4:2];
      slot_b  = f[7:5];
      // second slot written last, so it wins on a clash
      range_mem[slot_a] = {body_bytes[1], body_bytes[0]};
      range_mem[slot_b] = {body_bytes[3], body_bytes[2]};
      update_laser(0, {body_bytes[5], body_bytes[4]});
      update_laser(1, {body_bytes[7], body_bytes[6]});
   endtask

   task automatic decode_link_item(input req_type it);
      logic [7:0] b;
      b = it.rx_byte;
      if (it.kind == KIND_READ) begin
         n_reads++;
         status_reports.push_back(status_word(EV_READ, range_mem[it.read_index]));
         return;
      end
      n_bytes++;
      case (hunt)
         HUNT_SECOND: begin
            if (b == SYNC_BYTE) begin
               hunt       = IN_BODY;
               body_count = 0;
               body_sum   = '0;
            end else begin
               hunt = HUNT_FIRST;
            end
         end
         IN_BODY: begin
            if (body_count < PAYLOAD_LEN) begin
               // 0xFF here is payload, no resync
               body_bytes[body_count] = b;
               body_sum   = body_sum + b;
               body_count++;
            end else begin
               hunt       = HUNT_FIRST;
               body_count = 0;
               if (body_sum == b) begin
                  apply_payload();
                  n_good++;
                  status_reports.push_back(status_word(EV_GOOD, '0));
               end else begin
                  n_reject++;
                  status_reports.push_back(status_word(EV_REJECT, '0));
               end
               body_sum = '0;
            end
         end
         default: hunt = (b == SYNC_BYTE) ? HUNT_SECOND : HUNT_FIRST;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Item builders
   // ------------------------------------------------------------------------
   function automatic req_type link_byte(input logic [7:0] b);
      req_type it;
      it.kind       = KIND_BYTE;
      it.rx_byte    = b;
      it.read_index = 3'($urandom_range(0, 7));
      return it;
   endfunction

   function automatic req_type table_read(input logic [SLOT_W-1:0] idx);
      req_type it;
      it.kind       = KIND_READ;
      it.rx_byte    = 8'($urandom_range(0, 255));
      it.read_index = idx;
      return it;
   endfunction

   // laser readings cluster around the current limit and the special values
   function automatic logic [VALUE_W-1:0] laser_word();
      logic [VALUE_W-1:0] w;
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = {FAULT_MARK, 8'($urandom_range(0, 255))};
         2: w = limit_q - 16'd1;
         3: w = limit_q;
         4: w = limit_q + 16'd1;
         5: begin
            if (limit_q == '0) w = 16'($urandom_range(0, 65535));
            else w = 16'($urandom_range(0, int'(limit_q) - 1));
         end
         default: w = 16'($urandom_range(0, 65535));
      endcase
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Mismatch report
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------
   // called just after a rising edge; returns at the accepting edge, or after
   // an idle burst with valid low
   task automatic send_item(input req_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_items++;
      decode_link_item(it);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // sync pair, nine payload bytes and checksum; table reads may slip in
   task automatic send_frame(input payload_type body, input logic [7:0] sum_offset,
                             input int read_at, input int read_pct, input bit extra_sync);
      logic [7:0] sum;
      sum = sum_offset;
      for (int i = 0; i < PAYLOAD_LEN; i++) sum = sum + body[i];
      send_item(link_byte(SYNC_BYTE));
      send_item(link_byte(SYNC_BYTE));
      // a stray third sync shifts the whole frame by one byte
      if (extra_sync) send_item(link_byte(SYNC_BYTE));
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         if (i == read_at || $urandom_range(0, 99) < read_pct)
            send_item(table_read(3'($urandom_range(0, 7))));
         send_item(link_byte(body[i]));
      end
      send_item(link_byte(sum));
   endtask

   // drop valid, let every owed transfer arrive, then cover the pipe latency
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (status_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write then read-back of the distance limit, only while idle
   task automatic write_limit(input logic [VALUE_W-1:0] value);
      wait_quiet();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= {{(CSR_DATA_W-VALUE_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      limit_q = value;
      n_limits++;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {{(CSR_DATA_W-VALUE_W){1'b0}}, value})
         report_mismatch($sformatf("distance_limit read back %h, wrote %h", prdata, value));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // result side: random stall bursts while gaps are enabled
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= (stall_left == 0);
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s: got %h, expected %h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_reports.size() == 0) begin
            report_mismatch("result transfer with no result pending");
         end else begin
            want = status_reports.pop_front();
            check_field("event_res",       16'(rsp_data.event_res),   16'(want.event_res));
            check_field("ir_first",        16'(rsp_data.ir_first),    16'(want.ir_first));
            check_field("ir_second",       16'(rsp_data.ir_second),   16'(want.ir_second));
            check_field("slot_first",      16'(rsp_data.slot_first),  16'(want.slot_first));
            check_field("slot_second",     16'(rsp_data.slot_second), 16'(want.slot_second));
            check_field("table_value",     rsp_data.table_value,      want.table_value);
            check_field("laser0_distance", rsp_data.laser0_distance,  want.laser0_distance);
            check_field("laser0_on",       16'(rsp_data.laser0_on),   16'(want.laser0_on));
            check_field("laser0_fault",    16'(rsp_data.laser0_fault), 16'(want.laser0_fault));
            check_field("laser1_distance", rsp_data.laser1_distance,  want.laser1_distance);
            check_field("laser1_on",       16'(rsp_data.laser1_on),   16'(want.laser1_on));
            check_field("laser1_fault",    16'(rsp_data.laser1_fault), 16'(want.laser1_fault));
         end
      end
   end

   // watchdog: a hang on either channel or a missing result ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d results pending",
                     quiet_cycles, status_reports.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // table is all zero out of reset
   task automatic test_reset_reads();
      send_item(table_read(3'd0));
      send_item(table_read(3'd7));
   endtask

   // noise while hunting, then a sync followed by a non-sync byte
   task automatic test_sync_hunt();
      send_item(link_byte(8'h00));
      send_item(link_byte(SYNC_BYTE));
      send_item(link_byte(8'h7E));
   endtask

   // both slots 7 (second wins), 0xFF inside the payload, laser 0 fault
   // marker, laser 1 just under the reset limit, a read in mid-frame
   task automatic test_good_frame();
      payload_type body;
      body = {8'hFF, 8'h0F, 8'h9F, FAULT_MARK, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF};
      send_frame(body, 8'h00, 5, 0, 1'b0);
      send_item(table_read(3'd7));
   endtask

   // bad checksum must leave table and lasers untouched
   task automatic test_rejected_frame();
      payload_type body;
      body = {8'h60, 8'h0F, 8'hA0, 8'h00, 8'h00, 8'hAB, 8'hCD, 8'h12, 8'h34};
      send_frame(body, 8'h01, -1, 0, 1'b0);
      send_item(table_read(3'd0));
      send_item(table_read(3'd3));
   endtask

   // mostly well-formed frames with random content, plus reads and noise
   task automatic test_random_traffic(input logic [VALUE_W-1:0] limit_value,
                                      input int count, input bit allow_gaps);
      int          start;
      int          pick;
      payload_type body;
      logic [15:0] w;
      logic [7:0]  b;
      logic [7:0]  fudge;
      write_limit(limit_value);
      gaps_on = allow_gaps;
      start   = accepted_items;
      while (accepted_items - start < count) begin
         // switch gaps off now and then for stretches of back-to-back traffic
         if (allow_gaps && $urandom_range(0, 19) == 0) gaps_on = !gaps_on;
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            w = 16'($urandom_range(0, 65535));
            body[0] = w[7:0];
            body[1] = w[15:8];
            w = 16'($urandom_range(0, 65535));
            body[2] = w[7:0];
            body[3] = w[15:8];
            w = laser_word();
            body[4] = w[7:0];
            body[5] = w[15:8];
            w = laser_word();
            body[6] = w[7:0];
            body[7] = w[15:8];
            body[8] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) body[8][7:5] = body[8][4:2];
            fudge = '0;
            if ($urandom_range(0, 99) < 12) fudge = 8'($urandom_range(1, 255));
            send_frame(body, fudge, -1, 6, $urandom_range(0, 19) == 0);
         end else if (pick < 86) begin
            send_item(table_read(3'($urandom_range(0, 7))));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               b = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 2) == 0) b = SYNC_BYTE;
               send_item(link_byte(b));
            end
         end
      end
   endtask

   initial begin
      clear_tracker();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      gaps_on = 1'b1;
      test_reset_reads();
      test_sync_hunt();
      test_good_frame();
      test_rejected_frame();

      test_random_traffic(16'h0000, 220, 1'b1);
      test_random_traffic(16'hFFFF, 220, 1'b1);
      test_random_traffic(16'($urandom_range(1, 65534)), 220, 1'b1);
      test_random_traffic(16'($urandom_range(1, 4095)), 200, 1'b1);
      // closing phase runs flat out on both channels
      test_random_traffic(16'($urandom_range(0, 65535)), 180, 1'b0);

      wait_quiet();
      $display("Run covered %0d link bytes and %0d table reads, giving %0d good frames",
               n_bytes, n_reads, n_good);
      $display("and %0d checksum rejects over %0d distance limit settings.",
               n_reject, n_limits);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
